// ----- rtl/rfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants for the rational fraction ALU
// Op codes, word widths and the item record passed from front to back.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int unsigned IN_WIDTH_DEF = 32;
    localparam int unsigned OP_W         = 3;
    localparam int unsigned WORD_W       = 64;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_REDUCE = 3'd4,
        OP_PROPER = 3'd5,
        OP_RSV6   = 3'd6,
        OP_RSV7   = 3'd7
    } t_op;

    // item as classified by the front: operands for the back end
    typedef struct packed {
        logic              needs_reduce;
        logic [WORD_W-1:0] num;
        logic [WORD_W-1:0] den;
    } t_item;

endpackage

// ----- rtl/rational_fraction_alu_unit.sv -----
`timescale 1ns / 1ps
// Path: add/sub/mul/div and unused ops go from the front product steps
//   straight to the back output; reduce and proper part add a Euclid run.
// Flow: front takes no new item until the back has taken the last one from
//   its output register; a reducing item holds the back end for its whole
//   Euclid run, and the bit-serial divider sets the length of that run.
// Reset: synchronous active low, clears all control state; no data reset.
// ----------------------------------------------------------------------------
// rational_fraction_alu_unit: rational arithmetic with Euclid reduction
// Front forms cross products, back reduces with a shared serial divider.
// ----------------------------------------------------------------------------
module rational_fraction_alu_unit #(
    parameter int unsigned IN_WIDTH = rfa_pkg::IN_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_op,
    input  logic [IN_WIDTH-1:0]        i_a_num,
    input  logic [IN_WIDTH-1:0]        i_a_den,
    input  logic [IN_WIDTH-1:0]        i_b_num,
    input  logic [IN_WIDTH-1:0]        i_b_den,
    input  logic [IN_WIDTH-1:0]        i_whole_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [rfa_pkg::WORD_W-1:0] o_res_num,
    output logic [rfa_pkg::WORD_W-1:0] o_res_den,
    output logic                       o_is_zero,
    output logic                       o_gcd_error
);
    logic           w_q_valid, w_q_ready;
    rfa_pkg::t_item w_item;

    rfa_front #(.IN_WIDTH(IN_WIDTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_a_num       (i_a_num),
        .i_a_den       (i_a_den),
        .i_b_num       (i_b_num),
        .i_b_den       (i_b_den),
        .i_whole_count (i_whole_count),
        .o_valid       (w_q_valid),
        .i_ready       (w_q_ready),
        .o_item        (w_item)
    );

    rfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .o_ready     (w_q_ready),
        .i_item      (w_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res_num   (o_res_num),
        .o_res_den   (o_res_den),
        .o_is_zero   (o_is_zero),
        .o_gcd_error (o_gcd_error)
    );
endmodule

// ----- rtl/rfa_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_divider: 64-bit restoring divider, one quotient bit per cycle
// Truncating quotient and remainder of signed operands, divisor nonzero.
// ----------------------------------------------------------------------------
module rfa_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rfa_pkg::WORD_W-1:0] i_dividend,
    input  logic [rfa_pkg::WORD_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rfa_pkg::WORD_W-1:0] o_quot,
    output logic [rfa_pkg::WORD_W-1:0] o_rem
);
    localparam int unsigned W  = rfa_pkg::WORD_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  r_q, r_d, r_r;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, r_qneg, r_rneg;
    logic [W:0]    w_trial;
    logic [W-1:0]  w_shift;

    assign w_shift = {r_r[W-2:0], r_q[W-1]};
    assign w_trial = {r_r, r_q[W-1]} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_q    <= i_dividend[W-1] ? (W'(0) - i_dividend) : i_dividend;
                r_d    <= i_divisor[W-1] ? (W'(0) - i_divisor) : i_divisor;
                r_r    <= '0;
                r_qneg <= i_dividend[W-1] ^ i_divisor[W-1];
                r_rneg <= i_dividend[W-1];
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                if (!w_trial[W]) begin
                    r_r <= w_trial[W-1:0];
                    r_q <= {r_q[W-2:0], 1'b1};
                end else begin
                    r_r <= {w_shift[W-1:0]};
                    r_q <= {r_q[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_qneg ? (W'(0) - r_q) : r_q;
    assign o_rem  = r_rneg ? (W'(0) - r_r) : r_r;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without run");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy || $past(i_start))
        else $error("divider busy after done");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !$past(i_start)) |-> r_cnt == '0 || $past(!i_rst_n))
        else $error("divider count left over");
endmodule

// ----- rtl/rfa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_front: operand capture and cross products
// Sign-extends operands, forms products in steps S_P1 to S_P5, one multiplier.
// ----------------------------------------------------------------------------
module rfa_front #(
    parameter int unsigned IN_WIDTH = rfa_pkg::IN_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_op,
    input  logic [IN_WIDTH-1:0] i_a_num,
    input  logic [IN_WIDTH-1:0] i_a_den,
    input  logic [IN_WIDTH-1:0] i_b_num,
    input  logic [IN_WIDTH-1:0] i_b_den,
    input  logic [IN_WIDTH-1:0] i_whole_count,
    output logic                o_valid,
    input  logic                i_ready,
    output rfa_pkg::t_item      o_item
);
    localparam int unsigned W  = rfa_pkg::WORD_W;
    localparam int unsigned HW = W / 2;
    localparam int unsigned MW = HW + 1;

    typedef enum logic [2:0] {S_IDLE, S_P1, S_P2, S_P3, S_P4, S_P5, S_OUT} t_state;

    t_state                  r_state;
    rfa_pkg::t_op            r_op;
    logic [W-1:0]            r_an, r_ad;
    logic [MW-1:0]           r_bn, r_bd, r_wc;
    logic [W-1:0]            r_p1, r_p2, r_p3, r_p4;
    logic [MW-1:0]           w_ma, w_mb;
    logic signed [2*MW-1:0]  w_prod;
    logic [W-1:0]            w_mul;
    rfa_pkg::t_item          r_item;

    // one 33x33 signed product per step; ad*(ad*wc) is taken in two steps,
    // against the low and the high half of ad*wc
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_P1: begin
                w_ma = r_an[MW-1:0];
                w_mb = (r_op == rfa_pkg::OP_MUL) ? r_bn :
                       (r_op == rfa_pkg::OP_PROPER) ? r_ad[MW-1:0] : r_bd;
            end
            S_P2: begin
                w_ma = r_ad[MW-1:0];
                w_mb = (r_op == rfa_pkg::OP_PROPER) ? r_wc : r_bn;
            end
            S_P3: begin
                w_ma = r_ad[MW-1:0];
                w_mb = (r_op == rfa_pkg::OP_PROPER) ? r_ad[MW-1:0] : r_bd;
            end
            S_P4: begin
                w_ma = r_ad[MW-1:0];
                w_mb = {1'b0, r_p2[HW-1:0]};
            end
            S_P5: begin
                w_ma = r_ad[MW-1:0];
                w_mb = {1'b0, r_p2[W-1:HW]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = $signed(w_ma) * $signed(w_mb);
    assign w_mul  = w_prod[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op    <= rfa_pkg::t_op'(i_op);
                    r_an    <= W'(signed'(i_a_num));
                    r_ad    <= W'(signed'(i_a_den));
                    r_bn    <= MW'(signed'(i_b_num));
                    r_bd    <= MW'(signed'(i_b_den));
                    r_wc    <= MW'(signed'(i_whole_count));
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_p1    <= w_mul;
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_p2    <= w_mul;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_p3    <= w_mul;
                    r_state <= S_P4;
                end
                S_P4: begin
                    r_p4    <= w_mul;
                    r_state <= S_P5;
                end
                S_P5: begin
                    r_item.needs_reduce <= 1'b0;
                    unique case (r_op)
                        rfa_pkg::OP_ADD: begin
                            r_item.num <= r_p1 + r_p2;
                            r_item.den <= r_p3;
                        end
                        rfa_pkg::OP_SUB: begin
                            r_item.num <= r_p1 - r_p2;
                            r_item.den <= r_p3;
                        end
                        rfa_pkg::OP_MUL: begin
                            r_item.num <= r_p1;
                            r_item.den <= r_p3;
                        end
                        // divide: den is ad*bn from the second step
                        rfa_pkg::OP_DIV: begin
                            r_item.num <= r_p1;
                            r_item.den <= r_p2;
                        end
                        rfa_pkg::OP_REDUCE: begin
                            r_item.needs_reduce <= 1'b1;
                            r_item.num <= r_an;
                            r_item.den <= r_ad;
                        end
                        rfa_pkg::OP_PROPER: begin
                            r_item.needs_reduce <= 1'b1;
                            r_item.num <= r_p1 -
                                (r_p4 + {w_mul[HW-1:0], {HW{1'b0}}});
                            r_item.den <= r_p3;
                        end
                        default: begin
                            r_item.num <= '0;
                            r_item.den <= '0;
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_item;
endmodule

// ----- rtl/rfa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_back: Euclid reduction and result register
// Runs the remainder loop and the two final quotients on one shared divider.
// ----------------------------------------------------------------------------
module rfa_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  rfa_pkg::t_item            i_item,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rfa_pkg::WORD_W-1:0] o_res_num,
    output logic [rfa_pkg::WORD_W-1:0] o_res_den,
    output logic                      o_is_zero,
    output logic                      o_gcd_error
);
    localparam int unsigned W = rfa_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_GCD, S_GWAIT, S_QN, S_QNW, S_QDW, S_OUT
    } t_state;

    t_state       r_state;
    logic [W-1:0] r_n, r_d, r_c, r_e, r_qn;
    logic [W-1:0] r_rn, r_rd;
    logic         r_err;
    logic         w_start, w_done;
    logic [W-1:0] w_dvd, w_dvs, w_quot, w_rem;

    always_comb begin
        w_start = 1'b0;
        w_dvd   = r_c;
        w_dvs   = r_e;
        unique case (r_state)
            S_GCD: w_start = (r_e != '0);
            S_QN: begin
                w_start = 1'b1;
                w_dvd   = r_n;
                w_dvs   = r_c;
            end
            S_QNW: begin
                w_start = w_done;
                w_dvd   = r_d;
                w_dvs   = r_c;
            end
            default: w_start = 1'b0;
        endcase
    end

    rfa_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_n   <= i_item.num;
                    r_d   <= i_item.den;
                    r_c   <= i_item.num;
                    r_e   <= i_item.den;
                    r_rn  <= i_item.num;
                    r_rd  <= i_item.den;
                    r_err <= 1'b0;
                    r_state <= i_item.needs_reduce ? S_GCD : S_OUT;
                end
                S_GCD: begin
                    if (r_e != '0) begin
                        r_state <= S_GWAIT;
                    end else if (r_c == '0) begin
                        // both operands zero: flag and force zero
                        r_err   <= 1'b1;
                        r_rn    <= '0;
                        r_rd    <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_QN;
                    end
                end
                S_GWAIT: if (w_done) begin
                    r_c     <= r_e;
                    r_e     <= w_rem;
                    r_state <= S_GCD;
                end
                S_QN: r_state <= S_QNW;
                S_QNW: if (w_done) begin
                    r_qn    <= w_quot;
                    r_state <= S_QDW;
                end
                S_QDW: if (w_done) begin
                    r_rn    <= r_qn;
                    r_rd    <= w_quot;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_res_num   = r_rn;
    assign o_res_den   = r_rd;
    assign o_is_zero   = (r_rn == '0) || (r_rd == '0);
    assign o_gcd_error = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_gcd_error) |-> (o_res_num == '0 && o_res_den == '0))
        else $error("gcd error with nonzero result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_res_num))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("back end takes item while holding result");
endmodule
